@@ rtl/pta_pkg.sv @@
`timescale 1ns / 1ps

package pta_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W      = 2;
    localparam int FRAME_W     = 8;
    localparam int VA_W        = 32;
    localparam int PA_W        = 16;
    localparam int COUNT_W     = 9;
    localparam int STATUS_W    = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_XLATE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VA_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VPN_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  page_number;
        logic [FRAME_W-1:0]  page_offset;
        logic [FRAME_W-1:0]  frame_number;
        logic [PA_W-1:0]     physical_address;
        logic [COUNT_W-1:0]  pages_loaded;
    } result_t;

endpackage

@@ rtl/pta_ram.sv @@
`timescale 1ns / 1ps

module pta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/page_table_alloc_translate_unit.sv @@
`timescale 1ns / 1ps
// Single-level page table with a frame-occupancy bitmap.
// Input channel (in_valid/in_ready): one transaction carries func, frame_index and
// virtual_address. Output channel (out_valid/out_ready): one result transaction per
// input transaction, in order. Config channel (cfg_valid/cfg_ready, always ready):
// writes num_pages; write it only while the unit is idle.
// Path from input acceptance to result valid:
//   clear, mark, failed translate, load of zero pages: result register, next cycle
//   successful translate: page_frame memory read register, then result register
//   load: S_LOAD until page_limit frames are taken or allocation fails; one frame is
//   taken per cycle by the priority encoder over the occupancy bitmap.
// in_ready is low while an operation is in progress, so one transaction is at
// work at a time. The result sits in an output register; when the receiver
// stalls, hold it and accept no new input until it is taken (a new transaction is
// accepted in the same cycle the old result leaves).
// Reset: all frames free, all pages invalid, num_pages = 1, no result pending.
// page_frame contents are undefined after reset; only valid pages are read.

module page_table_alloc_translate_unit #(
    parameter int FRAMES        = 128,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  frame_index,
    input  logic [31:0] virtual_address,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  page_number,
    output logic [7:0]  page_offset,
    output logic [7:0]  frame_number,
    output logic [15:0] physical_address,
    output logic [8:0]  pages_loaded
);

    localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW          = pta_pkg::COUNT_W;
    localparam int FW          = pta_pkg::FRAME_W;

    localparam logic [CW-1:0] FRAMES_C  = CW'(FRAMES);
    localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_TRANS = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           num_pages_reg, num_pages_next;
    logic [FRAMES-1:0]       frame_busy_reg, frame_busy_next;
    logic [TABLE_ENTRIES-1:0] page_valid_reg, page_valid_next;
    logic [CW-1:0]           lim_reg, lim_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [FW-1:0]           tr_vpn_reg, tr_vpn_next;
    logic [FW-1:0]           tr_off_reg, tr_off_next;
    pta_pkg::result_t        out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    in_fire;
    logic [CW-1:0]           page_limit;
    logic                    free_found;
    logic [FW-1:0]           free_idx;
    logic [FW-1:0]           va_vpn;
    logic [FW-1:0]           va_off;
    logic [CW-1:0]           cnt_inc;

    logic                    ram_we;
    logic [PAGE_IDX_W-1:0]   ram_waddr;
    logic [FW-1:0]           ram_wdata;
    logic [PAGE_IDX_W-1:0]   ram_raddr;
    logic [FW-1:0]           ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;

    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign page_number      = out_reg.page_number;
    assign page_offset      = out_reg.page_offset;
    assign frame_number     = out_reg.frame_number;
    assign physical_address = out_reg.physical_address;
    assign pages_loaded     = out_reg.pages_loaded;

    // Clamp the page count to the table size
    assign page_limit = (num_pages_reg > ENTRIES_C) ? ENTRIES_C : num_pages_reg;

    assign va_vpn  = virtual_address[15:8];
    assign va_off  = virtual_address[7:0];
    assign cnt_inc = cnt_reg + CW'(1);

    // Lowest free frame: scan from the top so the lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!frame_busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = FW'(i);
            end
        end
    end

    // Translate reads page_frame at the accept edge; the frame shows up in S_TRANS
    assign ram_raddr = virtual_address[8 +: PAGE_IDX_W];
    assign ram_waddr = cnt_reg[PAGE_IDX_W-1:0];
    assign ram_wdata = free_idx;

    always_comb
    begin
        state_next      = state_reg;
        num_pages_next  = num_pages_reg;
        frame_busy_next = frame_busy_reg;
        page_valid_next = page_valid_reg;
        lim_next        = lim_reg;
        cnt_next        = cnt_reg;
        tr_vpn_next     = tr_vpn_reg;
        tr_off_next     = tr_off_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        ram_we          = 1'b0;

        if (cfg_valid)
        begin
            num_pages_next = cfg_data;
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_next = '0;
                    case (func)
                        pta_pkg::FUNC_CLEAR:
                        begin
                            frame_busy_next = '0;
                            out_valid_next  = 1'b1;
                        end
                        pta_pkg::FUNC_MARK:
                        begin
                            // Ignore frames beyond the bitmap
                            if ({1'b0, frame_index} < FRAMES_C)
                            begin
                                frame_busy_next[frame_index[FRAME_IDX_W-1:0]] = 1'b1;
                            end
                            out_valid_next = 1'b1;
                        end
                        pta_pkg::FUNC_LOAD:
                        begin
                            page_valid_next = '0;
                            lim_next        = page_limit;
                            cnt_next        = '0;
                            if (page_limit == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                            if (virtual_address[31:16] != '0)
                            begin
                                out_next.status = pta_pkg::ST_VA_RANGE;
                                out_valid_next  = 1'b1;
                            end
                            else if ({1'b0, va_vpn} >= page_limit)
                            begin
                                out_next.status      = pta_pkg::ST_VPN_RANGE;
                                out_next.page_number = va_vpn;
                                out_next.page_offset = va_off;
                                out_valid_next       = 1'b1;
                            end
                            else if (!page_valid_reg[va_vpn[PAGE_IDX_W-1:0]])
                            begin
                                out_next.status      = pta_pkg::ST_UNMAPPED;
                                out_next.page_number = va_vpn;
                                out_next.page_offset = va_off;
                                out_valid_next       = 1'b1;
                            end
                            else
                            begin
                                tr_vpn_next = va_vpn;
                                tr_off_next = va_off;
                                state_next  = S_TRANS;
                            end
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                // One allocation per cycle; partial mappings stay on failure
                out_next = '0;
                if (free_found)
                begin
                    frame_busy_next[free_idx[FRAME_IDX_W-1:0]] = 1'b1;
                    page_valid_next[cnt_reg[PAGE_IDX_W-1:0]]   = 1'b1;
                    ram_we   = 1'b1;
                    cnt_next = cnt_inc;
                    if (cnt_inc == lim_reg)
                    begin
                        out_next.pages_loaded = cnt_inc;
                        out_valid_next        = 1'b1;
                        state_next            = S_IDLE;
                    end
                end
                else
                begin
                    out_next.status       = pta_pkg::ST_ALLOC_FAIL;
                    out_next.pages_loaded = cnt_reg;
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_TRANS:
            begin
                out_next                  = '0;
                out_next.page_number      = tr_vpn_reg;
                out_next.page_offset      = tr_off_reg;
                out_next.frame_number     = ram_rdata;
                out_next.physical_address = {ram_rdata, tr_off_reg};
                out_valid_next            = 1'b1;
                state_next                = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_pages_reg  <= CW'(1);
            frame_busy_reg <= '0;
            page_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            num_pages_reg  <= num_pages_next;
            frame_busy_reg <= frame_busy_next;
            page_valid_reg <= page_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg    <= lim_next;
        cnt_reg    <= cnt_next;
        tr_vpn_reg <= tr_vpn_next;
        tr_off_reg <= tr_off_next;
        out_reg    <= out_next;
    end

    pta_ram #(
        .WIDTH (FW),
        .DEPTH (TABLE_ENTRIES)
    ) u_page_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (cnt_reg < lim_reg))
        else $error("load counter reached the page limit while still loading");

    a_trans_mapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRANS) |-> page_valid_reg[tr_vpn_reg[PAGE_IDX_W-1:0]])
        else $error("frame lookup started for an unmapped page");

    a_alloc_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && !free_found)
        |=> (out_valid_reg && out_reg.status == pta_pkg::ST_ALLOC_FAIL))
        else $error("exhausted frames did not report allocation failure");

    a_va_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == pta_pkg::ST_VA_RANGE)
        |-> (out_reg.page_number == '0 && out_reg.physical_address == '0))
        else $error("out-of-range address result carries nonzero fields");
`endif

endmodule

@@ tb/sv/page_table_checker.sv @@
`timescale 1ns / 1ps

module page_table_checker #(
    parameter int FRAMES        = 128,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  frame_index,
    input  logic [31:0] virtual_address,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [7:0]  page_number,
    input  logic [7:0]  page_offset,
    input  logic [7:0]  frame_number,
    input  logic [15:0] physical_address,
    input  logic [8:0]  pages_loaded,

    output int          fail_count,
    output int          results_due
);

    bit [FRAMES-1:0]        frame_busy;
    bit [TABLE_ENTRIES-1:0] page_valid;
    logic [7:0]             page_frame [TABLE_ENTRIES];
    logic [8:0]             num_pages = 9'd1;
    pta_pkg::result_t       xlate_results_due [$];

    // Advance the page table copy by one operation and return its result.
    function automatic pta_pkg::result_t apply_page_op(input logic [1:0] op,
                                                       input logic [7:0] fidx,
                                                       input logic [31:0] va);
        pta_pkg::result_t r;
        int      lim;
        int      i;
        int      f;
        int      vpn;
        bit      got;
        r   = '0;
        lim = (num_pages > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(num_pages);
        case (op)
            pta_pkg::FUNC_CLEAR: frame_busy = '0;
            pta_pkg::FUNC_MARK: begin
                if (fidx < FRAMES)
                    frame_busy[fidx] = 1'b1;
            end
            pta_pkg::FUNC_LOAD: begin
                page_valid = '0;
                for (i = 0; i < lim; i++) begin
                    got = 1'b0;
                    for (f = 0; f < FRAMES; f++) begin
                        if (!frame_busy[f]) begin
                            frame_busy[f] = 1'b1;
                            page_frame[i] = f[7:0];
                            got = 1'b1;
                            break;
                        end
                    end
                    if (!got) begin
                        r.status = pta_pkg::ST_ALLOC_FAIL;
                        break;
                    end
                    page_valid[i]  = 1'b1;
                    r.pages_loaded = r.pages_loaded + 9'd1;
                end
            end
            default: begin
                if (va > 32'hFFFF) begin
                    r.status = pta_pkg::ST_VA_RANGE;
                end else begin
                    r.page_offset = va[7:0];
                    r.page_number = va[15:8];
                    vpn = int'(va[15:8]);
                    if (vpn >= lim) begin
                        r.status = pta_pkg::ST_VPN_RANGE;
                    end else if (!page_valid[vpn]) begin
                        r.status = pta_pkg::ST_UNMAPPED;
                    end else begin
                        r.frame_number     = page_frame[vpn];
                        r.physical_address = {page_frame[vpn], va[7:0]};
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pta_pkg::result_t want;
        if (!rst_n) begin
            frame_busy = '0;
            page_valid = '0;
            num_pages  = 9'd1;
            xlate_results_due.delete();
            results_due <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                num_pages = cfg_data;
            if (out_valid && out_ready) begin
                if (xlate_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected, expected nothing, actual status %0d",
                             $time, status);
                end else begin
                    want = xlate_results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("page_number", 32'(want.page_number), 32'(page_number));
                    check_field("page_offset", 32'(want.page_offset), 32'(page_offset));
                    check_field("frame_number", 32'(want.frame_number), 32'(frame_number));
                    check_field("physical_address", 32'(want.physical_address),
                                32'(physical_address));
                    check_field("pages_loaded", 32'(want.pages_loaded), 32'(pages_loaded));
                end
            end
            if (in_valid && in_ready)
                xlate_results_due.push_back(apply_page_op(func, frame_index, virtual_address));
            results_due <= xlate_results_due.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int FRAMES         = 128;
    localparam int TABLE_ENTRIES  = 256;
    localparam int ITEMS          = 1600;
    // A load maps at most 128 pages before the frames run out; long sender gaps and
    // receiver stalls add to it. Allow many times that with no transaction at all.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = pta_pkg::FUNC_CLEAR;
    logic [7:0]  frame_index = '0;
    logic [31:0] virtual_address = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  page_number;
    logic [7:0]  page_offset;
    logic [7:0]  frame_number;
    logic [15:0] physical_address;
    logic [8:0]  pages_loaded;

    int          fail_count;
    int          results_due;

    int          items_sent = 0;
    int          idle_cycles = 0;
    int          cur_pages = 1;     // num_pages as last written, for stimulus shaping
    bit          tx_eager = 1'b0;   // sender runs without gaps
    logic        rx_eager = 1'b0;   // receiver never stalls
    int          rx_hold = 0;

    always #10 clk = ~clk;

    page_table_alloc_translate_unit #(
        .FRAMES        (FRAMES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .frame_index      (frame_index),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .page_number      (page_number),
        .page_offset      (page_offset),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .pages_loaded     (pages_loaded)
    );

    page_table_checker #(
        .FRAMES        (FRAMES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .frame_index      (frame_index),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .page_number      (page_number),
        .page_offset      (page_offset),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .pages_loaded     (pages_loaded),
        .fail_count       (fail_count),
        .results_due      (results_due)
    );

    // Idle length: mostly none, sometimes a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: after each result transaction, or at random while waiting,
    // hold out_ready low for a random stretch.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            rx_hold = rx_eager ? 0 : pick_gap();
        else if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (!rx_eager && $urandom_range(0, 15) == 0)
            rx_hold = pick_gap();
        out_ready <= (rx_hold == 0);
    end

    // Watchdog: end the run if no transaction moves on any channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one input transaction, after a random gap, and hold it until accepted.
    // Returns in the time step of the accepting edge.
    task automatic push_item(input logic [1:0] op, input logic [7:0] fidx,
                             input logic [31:0] va);
        int gap;
        gap = tx_eager ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= op;
        frame_index     <= fidx;
        virtual_address <= va;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every result transaction owed has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // Write num_pages with the unit idle.
    task automatic write_pages(input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value[8:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_pages = value;
    endtask

    // Address for translation: mostly a page inside the current page limit,
    // some pages past it, some addresses above the 16-bit space.
    function automatic logic [31:0] make_va();
        int lim;
        int r;
        lim = (cur_pages > TABLE_ENTRIES) ? TABLE_ENTRIES : cur_pages;
        r   = $urandom_range(0, 99);
        if (r < 75 && lim > 0)
            return {16'h0000, 8'($urandom_range(0, lim - 1)), 8'($urandom)};
        else if (r < 88)
            return {16'h0000, 16'($urandom)};
        else if (r < 95)
            return $urandom_range(32'h0001_0000, 32'hFFFF_FFFF);
        return $urandom;
    endfunction

    function automatic logic [1:0] any_op();
        case ($urandom_range(0, 3))
            0:       return pta_pkg::FUNC_CLEAR;
            1:       return pta_pkg::FUNC_MARK;
            2:       return pta_pkg::FUNC_LOAD;
            default: return pta_pkg::FUNC_XLATE;
        endcase
    endfunction

    // One burst of traffic: mostly an allocate-then-translate sequence with
    // random content, otherwise random noise of any operation.
    task automatic run_sequence();
        int n;
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 1)
                push_item(pta_pkg::FUNC_CLEAR, 8'($urandom), $urandom);
            n = $urandom_range(0, 4);
            repeat (n) begin
                if ($urandom_range(0, 4) != 0)
                    push_item(pta_pkg::FUNC_MARK, 8'($urandom_range(0, FRAMES - 1)), $urandom);
                else
                    push_item(pta_pkg::FUNC_MARK, 8'($urandom), $urandom);
            end
            push_item(pta_pkg::FUNC_LOAD, 8'($urandom), $urandom);
            n = $urandom_range(3, 10);
            repeat (n)
                push_item(pta_pkg::FUNC_XLATE, 8'($urandom), make_va());
        end else begin
            n = $urandom_range(1, 6);
            repeat (n)
                push_item(any_op(), 8'($urandom), $urandom);
        end
        // Now and then hold the sender until the unit has caught up.
        if ($urandom_range(0, 19) == 0)
            drain_results();
    endtask

    initial begin
        int start;
        int phase;
        int phase_end;
        int pages;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from num_pages at its reset value of one.
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0000);   // nothing loaded yet: unmapped
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);    // page 0 takes frame 0
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_00FF);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0100);   // page past the limit
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0001_0000);   // just above the 16-bit space
        push_item(pta_pkg::FUNC_XLATE, 8'hFF, 32'hFFFF_FFFF);
        push_item(pta_pkg::FUNC_MARK, 8'd0, 32'h0000_0000);     // already occupied
        push_item(pta_pkg::FUNC_MARK, 8'd127, 32'h0000_0000);   // last frame
        push_item(pta_pkg::FUNC_MARK, 8'd128, 32'h0000_0000);   // beyond the frames: ignored
        push_item(pta_pkg::FUNC_MARK, 8'd255, 32'hFFFF_FFFF);
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);    // frame 0 stays taken
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0012);

        // Zero page count: load maps nothing, every translation is out of range.
        write_pages(0);
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0000);
        push_item(pta_pkg::FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF);

        // Page count beyond the table: limited to the table, runs out of frames.
        write_pages(511);
        push_item(pta_pkg::FUNC_MARK, 8'd5, 32'h0000_0000);
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_FFFF);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_7EAB);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0534);
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);    // no frame free at all
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_0000);
        push_item(pta_pkg::FUNC_CLEAR, 8'h00, 32'h0000_0000);

        write_pages(256);
        push_item(pta_pkg::FUNC_LOAD, 8'h00, 32'h0000_0000);
        push_item(pta_pkg::FUNC_XLATE, 8'h00, 32'h0000_FF00);

        // Random part: phases of traffic, each under its own page count.
        start = items_sent;
        phase = 0;
        while (items_sent - start < ITEMS) begin
            if (phase % 4 == 0) begin
                case ($urandom_range(0, 6))
                    0:       pages = 0;
                    1:       pages = 1;
                    2:       pages = 127;
                    3:       pages = 128;
                    4:       pages = 129;
                    5:       pages = 256;
                    default: pages = 511;
                endcase
            end else if ($urandom_range(0, 3) == 0)
                pages = $urandom_range(17, 255);
            else
                pages = $urandom_range(1, 16);
            write_pages(pages);
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager <= ($urandom_range(0, 4) == 0);
            phase_end = items_sent + $urandom_range(60, 120);
            while (items_sent < phase_end)
                run_sequence();
            phase++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pta_pkg.sv
rtl/pta_ram.sv
rtl/page_table_alloc_translate_unit.sv
tb/sv/page_table_checker.sv
tb/sv/tb.sv
